// File: design/pfc_pkg.sv
// ----------------------------------------------------------------------------
// pfc_pkg: shared types, constants and helpers for the Playfair digraph cipher
// Letter codes, key square layout, payload words and cell position helpers.
// ----------------------------------------------------------------------------
package pfc_pkg;

    localparam int SIDE   = 5;
    localparam int CELLS  = SIDE * SIDE;
    localparam int CODE_W = 5;
    localparam int REG_W  = 60;
    localparam int POS_W  = 3;   // row or column, 0..SIDE-1
    localparam int IDX_W  = 5;   // cell index, 0..CELLS-1
    localparam int CFG_IDX_W = 2;

    typedef logic [CODE_W-1:0] code_t;
    typedef logic [CELLS-1:0][CODE_W-1:0] square_t;
    typedef logic [CELLS-1:0] match_t;

    typedef enum logic [1:0] {
        STATUS_OK     = 2'd0,
        STATUS_ABSENT = 2'd1,
        STATUS_SAME   = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CELLS_LOW = 2'd0,
        CFG_CELLS_MID = 2'd1,
        CFG_CELL_LAST = 2'd2
    } cfg_index_t;

    typedef struct packed {
        code_t first_letter;
        code_t second_letter;
        logic  decrypt;
    } pair_word_t;

    typedef struct packed {
        code_t   out_first;
        code_t   out_second;
        status_t status;
    } result_word_t;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] idx;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
    } pos_t;

    // one step along a row or column, wrapping at both ends
    function automatic logic [POS_W-1:0] wrap_step(logic [POS_W-1:0] v, logic dec);
        logic [POS_W-1:0] r;
        if (dec)
        begin
            r = (v == '0) ? POS_W'(SIDE - 1) : v - POS_W'(1);
        end
        else
        begin
            r = (v == POS_W'(SIDE - 1)) ? '0 : v + POS_W'(1);
        end
        return r;
    endfunction

    // row * 5 + col
    function automatic logic [IDX_W-1:0] cell_index(logic [POS_W-1:0] row,
                                                     logic [POS_W-1:0] col);
        return {row, 2'b00} + {2'b00, row} + {2'b00, col};
    endfunction

endpackage

// File: design/pfc_find.sv
// ----------------------------------------------------------------------------
// pfc_find: two-stage letter locator
// Stage one compares the letter against every cell of the square; stage two
// picks the first hit in row-major order and registers its row and column.
// ----------------------------------------------------------------------------
module pfc_find
(
    input  logic            clk,
    input  pfc_pkg::square_t square,
    input  pfc_pkg::code_t   letter,
    input  logic            load_match,
    input  logic            load_pos,
    output pfc_pkg::pos_t    pos
);

    pfc_pkg::match_t match_reg;
    pfc_pkg::match_t match_next;
    pfc_pkg::pos_t   pos_reg;
    pfc_pkg::pos_t   pos_next;

    always_comb
    begin
        for (int k = 0; k < pfc_pkg::CELLS; k++)
        begin
            match_next[k] = (square[k] == letter);
        end
    end

    // first hit wins where the square repeats a code
    always_comb
    begin
        pos_next = '0;
        for (int r = 0; r < pfc_pkg::SIDE; r++)
        begin
            for (int c = 0; c < pfc_pkg::SIDE; c++)
            begin
                if (!pos_next.found && match_reg[r * pfc_pkg::SIDE + c])
                begin
                    pos_next.found = 1'b1;
                    pos_next.idx   = pfc_pkg::IDX_W'(r * pfc_pkg::SIDE + c);
                    pos_next.row   = pfc_pkg::POS_W'(r);
                    pos_next.col   = pfc_pkg::POS_W'(c);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_match)
        begin
            match_reg <= match_next;
        end
        if (load_pos)
        begin
            pos_reg <= pos_next;
        end
    end

    assign pos = pos_reg;

endmodule

// File: design/playfair_digraph_cipher.sv
// ----------------------------------------------------------------------------
// playfair_digraph_cipher: pipelined Playfair digraph transform
// Encrypts or decrypts one letter pair per cycle, unless the output stalls, against a 5x5 key square.
// ----------------------------------------------------------------------------
// Usage:
//   Load the key square through the cfg channel (index 0: cells 0..11,
//   index 1: cells 12..23, index 2: cell 24; 5-bit codes, row-major, cell k
//   at bits 5k+4..5k of its register). cfg_ready is always high. Write only
//   while the pipeline is empty.
//   A pair word is taken on pair_valid && !pair_stall; its result word leaves
//   on result_valid && !result_stall.
//   Each word passes four registered stages (match, encode, shift/swap,
//   cell read-out) before result_valid. Throughput: one word per cycle while
//   result_stall is low, set by the four-stage pipeline with no shared unit.
//   When the receiver stalls, each stage holds only while the stage after it
//   is full and held, so bubbles close up and the output register keeps the
//   waiting word; pair_stall rises only once all four stages are full.
//   Reset clears all stage valids and the key square to zeros.
//   Status: ok, absent (a letter matches no cell) or same cell; in the two
//   error cases the pair passes through unchanged.
// ----------------------------------------------------------------------------
module playfair_digraph_cipher
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [pfc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [pfc_pkg::REG_W-1:0]            cfg_data,
    input  logic                                 pair_valid,
    output logic                                 pair_stall,
    input  pfc_pkg::pair_word_t                  pair_word,
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output pfc_pkg::result_word_t                result_word
);

    // key square
    logic [pfc_pkg::REG_W-1:0]  cells_low_reg;
    logic [pfc_pkg::REG_W-1:0]  cells_mid_reg;
    pfc_pkg::code_t             cell_last_reg;
    pfc_pkg::square_t           square;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cells_low_reg <= '0;
            cells_mid_reg <= '0;
            cell_last_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                pfc_pkg::CFG_CELLS_LOW: cells_low_reg <= cfg_data;
                pfc_pkg::CFG_CELLS_MID: cells_mid_reg <= cfg_data;
                pfc_pkg::CFG_CELL_LAST: cell_last_reg <= cfg_data[pfc_pkg::CODE_W-1:0];
                default: ;
            endcase
        end
    end

    assign square = {cell_last_reg, cells_mid_reg, cells_low_reg};

    // stage valids and load enables
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;

    assign en4 = !v4_reg || !result_stall;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign pair_stall = !en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= pair_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
        end
    end

    // stages 1 and 2: locate both letters
    pfc_pkg::pos_t pos_a, pos_b;

    pfc_find u_find_a
    (
        .clk        (clk),
        .square     (square),
        .letter     (pair_word.first_letter),
        .load_match (en1),
        .load_pos   (en2),
        .pos        (pos_a)
    );

    pfc_find u_find_b
    (
        .clk        (clk),
        .square     (square),
        .letter     (pair_word.second_letter),
        .load_match (en1),
        .load_pos   (en2),
        .pos        (pos_b)
    );

    pfc_pkg::pair_word_t s1_word_reg, s2_word_reg;

    always_ff @(posedge clk)
    begin
        if (en1) s1_word_reg <= pair_word;
        if (en2) s2_word_reg <= s1_word_reg;
    end

    // stage 3: rule selection and target cells
    pfc_pkg::status_t            status3_reg, status3_next;
    pfc_pkg::code_t              a3_reg, b3_reg;
    logic [pfc_pkg::IDX_W-1:0]   ia3_reg, ia3_next, ib3_reg, ib3_next;

    always_comb
    begin
        logic [pfc_pkg::POS_W-1:0] ra, ca, rb, cb;
        ra = pos_a.row;
        ca = pos_a.col;
        rb = pos_b.row;
        cb = pos_b.col;
        if (!pos_a.found || !pos_b.found)
        begin
            status3_next = pfc_pkg::STATUS_ABSENT;
        end
        else if (pos_a.idx == pos_b.idx)
        begin
            status3_next = pfc_pkg::STATUS_SAME;
        end
        else
        begin
            status3_next = pfc_pkg::STATUS_OK;
        end
        if (pos_a.row == pos_b.row)
        begin
            ca = pfc_pkg::wrap_step(pos_a.col, s2_word_reg.decrypt);
            cb = pfc_pkg::wrap_step(pos_b.col, s2_word_reg.decrypt);
        end
        else if (pos_a.col == pos_b.col)
        begin
            ra = pfc_pkg::wrap_step(pos_a.row, s2_word_reg.decrypt);
            rb = pfc_pkg::wrap_step(pos_b.row, s2_word_reg.decrypt);
        end
        else
        begin
            ca = pos_b.col;
            cb = pos_a.col;
        end
        ia3_next = pfc_pkg::cell_index(ra, ca);
        ib3_next = pfc_pkg::cell_index(rb, cb);
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            status3_reg <= status3_next;
            a3_reg      <= s2_word_reg.first_letter;
            b3_reg      <= s2_word_reg.second_letter;
            ia3_reg     <= ia3_next;
            ib3_reg     <= ib3_next;
        end
    end

    // stage 4: read out the target cells
    pfc_pkg::result_word_t result_reg, result_next;

    always_comb
    begin
        result_next.status = status3_reg;
        if (status3_reg == pfc_pkg::STATUS_OK)
        begin
            result_next.out_first  = square[ia3_reg];
            result_next.out_second = square[ib3_reg];
        end
        else
        begin
            result_next.out_first  = a3_reg;
            result_next.out_second = b3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = v4_reg;
    assign result_word  = result_reg;

endmodule

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for playfair_digraph_cipher
// Loads a series of key squares (keyword, distinct codes, raw random, all
// zero, all ones, few letters), sends directed and random letter pairs with
// random gaps and output stalls, and checks each result word against an
// in-bench Playfair predictor.
// ----------------------------------------------------------------------------
module tb;

    localparam int RUN_LIMIT    = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int N_PHASES     = 10;
    localparam int BATCH_PAIRS  = 78;

    localparam bit [8*pfc_pkg::CELLS-1:0] KEY_TEXT = "PLAYFIREXMBCDGHKNOQSTUVWZ";

    typedef enum int {
        SQ_KEYWORD,
        SQ_DISTINCT,
        SQ_RAW,
        SQ_ALL_ONES,
        SQ_ZERO,
        SQ_FEW
    } square_kind_t;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [pfc_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [pfc_pkg::REG_W-1:0]     cfg_data;
    logic                          pair_valid;
    logic                          pair_stall;
    pfc_pkg::pair_word_t           pair_word;
    logic                          result_valid;
    logic                          result_stall;
    pfc_pkg::result_word_t         result_word;

    pfc_pkg::code_t        key_sq  [pfc_pkg::CELLS];
    pfc_pkg::code_t        next_sq [pfc_pkg::CELLS];
    pfc_pkg::pair_word_t   pending_pairs [$];
    pfc_pkg::result_word_t results_due [$];
    int                    mismatches  = 0;
    int                    cycle_count = 0;

    playfair_digraph_cipher dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pair_valid   (pair_valid),
        .pair_stall   (pair_stall),
        .pair_word    (pair_word),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_word  (result_word)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // busy about two thirds of the time, with a gap-free stretch that recurs periodically
    function automatic bit go_now();
        return ((cycle_count % 3000) < 500) || ($urandom_range(0, 99) >= 34);
    endfunction

    // first cell, row-major, holding the code; -1 if none
    function automatic int cell_of(pfc_pkg::code_t c);
        int k;
        cell_of = -1;
        for (k = pfc_pkg::CELLS - 1; k >= 0; k--)
            if (key_sq[k] == c)
                cell_of = k;
    endfunction

    function automatic pfc_pkg::result_word_t cipher_pair(pfc_pkg::pair_word_t w);
        pfc_pkg::result_word_t r;
        int pa, pb, ra, ca, rb, cb, stp, t;
        r.out_first  = w.first_letter;
        r.out_second = w.second_letter;
        r.status     = pfc_pkg::STATUS_OK;
        pa = cell_of(w.first_letter);
        pb = cell_of(w.second_letter);
        if (pa < 0 || pb < 0)
            r.status = pfc_pkg::STATUS_ABSENT;
        else if (pa == pb)
            r.status = pfc_pkg::STATUS_SAME;
        else
        begin
            stp = w.decrypt ? pfc_pkg::SIDE - 1 : 1;
            ra = pa / pfc_pkg::SIDE;
            ca = pa % pfc_pkg::SIDE;
            rb = pb / pfc_pkg::SIDE;
            cb = pb % pfc_pkg::SIDE;
            if (ra == rb)
            begin
                ca = (ca + stp) % pfc_pkg::SIDE;
                cb = (cb + stp) % pfc_pkg::SIDE;
            end
            else if (ca == cb)
            begin
                ra = (ra + stp) % pfc_pkg::SIDE;
                rb = (rb + stp) % pfc_pkg::SIDE;
            end
            else
            begin
                t  = ca;
                ca = cb;
                cb = t;
            end
            r.out_first  = key_sq[ra * pfc_pkg::SIDE + ca];
            r.out_second = key_sq[rb * pfc_pkg::SIDE + cb];
        end
        return r;
    endfunction

    function automatic pfc_pkg::code_t ltr(byte ch);
        return pfc_pkg::code_t'(ch - 8'd65);
    endfunction

    // sender: holds a stalled word, otherwise takes the next pending pair or idles
    always @(posedge clk)
    begin
        if (pair_valid && !pair_stall)
            results_due.push_back(cipher_pair(pair_word));
        if (!pair_valid || !pair_stall)
        begin
            if (rst_n && pending_pairs.size() != 0 && go_now())
            begin
                pair_word  <= pending_pairs.pop_front();
                pair_valid <= 1'b1;
            end
            else
                pair_valid <= 1'b0;
        end
    end

    task automatic note_mismatch(input string field, input int want, input int got);
        mismatches++;
        $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
    endtask

    // receiver: checks each accepted result word against the oldest prediction
    always @(posedge clk)
    begin
        pfc_pkg::result_word_t want;
        if (result_valid && !result_stall)
        begin
            if (results_due.size() == 0)
                note_mismatch("unexpected result word, out_first", -1,
                              int'(result_word.out_first));
            else
            begin
                want = results_due.pop_front();
                if (result_word.out_first !== want.out_first)
                    note_mismatch("out_first", int'(want.out_first),
                                  int'(result_word.out_first));
                if (result_word.out_second !== want.out_second)
                    note_mismatch("out_second", int'(want.out_second),
                                  int'(result_word.out_second));
                if (result_word.status !== want.status)
                    note_mismatch("status", int'(want.status), int'(result_word.status));
            end
        end
        result_stall <= !go_now();
    end

    task automatic write_reg(input pfc_pkg::cfg_index_t idx,
                             input logic [pfc_pkg::REG_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_square();
        logic [pfc_pkg::REG_W-1:0] lo, mid, last;
        int k;
        lo  = '0;
        mid = '0;
        for (k = 0; k < 12; k++)
        begin
            lo[5*k +: 5]  = next_sq[k];
            mid[5*k +: 5] = next_sq[k + 12];
        end
        // junk above the cell code half of the time; only the low 5 bits count
        last = pfc_pkg::REG_W'({$urandom, $urandom});
        if ($urandom_range(0, 1) == 0)
            last = '0;
        last[4:0] = next_sq[pfc_pkg::CELLS - 1];
        write_reg(pfc_pkg::CFG_CELLS_LOW, lo);
        write_reg(pfc_pkg::CFG_CELLS_MID, mid);
        write_reg(pfc_pkg::CFG_CELL_LAST, last);
        for (k = 0; k < pfc_pkg::CELLS; k++)
            key_sq[k] = next_sq[k];
    endtask

    task automatic fill_square(input square_kind_t kind);
        int pool [32];
        int i, j, t, span;
        span = (kind == SQ_KEYWORD) ? 26 : 32;
        for (i = 0; i < 32; i++)
            pool[i] = i;
        for (i = span - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            t = pool[i];
            pool[i] = pool[j];
            pool[j] = t;
        end
        for (i = 0; i < pfc_pkg::CELLS; i++)
        begin
            case (kind)
                SQ_KEYWORD, SQ_DISTINCT: next_sq[i] = pfc_pkg::code_t'(pool[i]);
                SQ_RAW:      next_sq[i] = pfc_pkg::code_t'($urandom_range(0, 31));
                SQ_ALL_ONES: next_sq[i] = '1;
                SQ_ZERO:     next_sq[i] = '0;
                default:     next_sq[i] = pfc_pkg::code_t'($urandom_range(0, 3));
            endcase
        end
    endtask

    task automatic queue_pair(input pfc_pkg::code_t a, input pfc_pkg::code_t b,
                              input bit dec);
        pfc_pkg::pair_word_t w;
        w.first_letter  = a;
        w.second_letter = b;
        w.decrypt       = dec;
        pending_pairs.push_back(w);
    endtask

    // mostly letters taken from the square, biased toward shared rows and columns
    task automatic queue_random_pair();
        int a, b;
        pfc_pkg::code_t fa, fb;
        a = $urandom_range(0, pfc_pkg::CELLS - 1);
        case ($urandom_range(0, 3))
            0:       b = (a / pfc_pkg::SIDE) * pfc_pkg::SIDE
                         + $urandom_range(0, pfc_pkg::SIDE - 1);
            1:       b = $urandom_range(0, pfc_pkg::SIDE - 1) * pfc_pkg::SIDE
                         + a % pfc_pkg::SIDE;
            default: b = $urandom_range(0, pfc_pkg::CELLS - 1);
        endcase
        fa = key_sq[a];
        fb = key_sq[b];
        if ($urandom_range(0, 9) == 0)
            fa = pfc_pkg::code_t'($urandom_range(0, 31));
        if ($urandom_range(0, 9) == 0)
            fb = pfc_pkg::code_t'($urandom_range(0, 31));
        queue_pair(fa, fb, bit'($urandom_range(0, 1)));
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (pending_pairs.size() != 0 || pair_valid || results_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        int k, p;
        for (k = 0; k < pfc_pkg::CELLS; k++)
            key_sq[k] = '0;
        rst_n        <= 1'b0;
        cfg_valid    <= 1'b0;
        cfg_index    <= pfc_pkg::CFG_CELLS_LOW;
        cfg_data     <= '0;
        pair_valid   <= 1'b0;
        pair_word    <= '0;
        result_stall <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // square after reset: every cell is A
        @(negedge clk);
        queue_pair(ltr("A"), ltr("A"), 1'b0);
        queue_pair(ltr("A"), ltr("B"), 1'b1);
        queue_pair(pfc_pkg::code_t'(31), ltr("A"), 1'b0);
        wait_drained();

        for (k = 0; k < pfc_pkg::CELLS; k++)
            next_sq[k] = ltr(KEY_TEXT[8*(pfc_pkg::CELLS-1-k) +: 8]);
        load_square();
        @(negedge clk);
        // row wrap both ways
        queue_pair(ltr("Y"), ltr("F"), 1'b0);
        queue_pair(ltr("P"), ltr("L"), 1'b1);
        queue_pair(ltr("L"), ltr("A"), 1'b0);
        queue_pair(ltr("L"), ltr("A"), 1'b1);
        // column wrap both ways
        queue_pair(ltr("P"), ltr("T"), 1'b0);
        queue_pair(ltr("P"), ltr("I"), 1'b1);
        queue_pair(ltr("F"), ltr("Z"), 1'b0);
        queue_pair(ltr("Z"), ltr("M"), 1'b1);
        // rectangle, including the end codes
        queue_pair(ltr("H"), ltr("I"), 1'b0);
        queue_pair(ltr("H"), ltr("I"), 1'b1);
        queue_pair(ltr("Z"), ltr("A"), 1'b0);
        queue_pair(ltr("A"), ltr("Z"), 1'b1);
        // letter missing from the square
        queue_pair(ltr("J"), ltr("A"), 1'b0);
        queue_pair(ltr("A"), ltr("J"), 1'b1);
        queue_pair(pfc_pkg::code_t'(26), ltr("Z"), 1'b0);
        queue_pair(pfc_pkg::code_t'(31), pfc_pkg::code_t'(31), 1'b1);
        queue_pair(ltr("A"), pfc_pkg::code_t'(31), 1'b0);
        // both letters on one cell
        queue_pair(ltr("A"), ltr("A"), 1'b0);
        queue_pair(ltr("Z"), ltr("Z"), 1'b1);
        queue_pair(ltr("P"), ltr("P"), 1'b0);
        wait_drained();

        for (p = 0; p < N_PHASES; p++)
        begin
            fill_square(square_kind_t'(p % 6));
            load_square();
            @(negedge clk);
            // drain mid-phase too, so the sender sits idle with the pipe empty
            repeat (2)
            begin
                repeat (BATCH_PAIRS) queue_random_pair();
                wait_drained();
            end
        end

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        wait (cycle_count >= RUN_LIMIT);
        $display("Mismatches found");
        $finish;
    end

endmodule
